>>> sv/sha1s_pkg.sv
package sha1s_pkg;

    localparam int WordW    = 32;
    localparam int NumWords = 5;
    localparam int WinDepth = 16;
    localparam int NumRnds  = 80;
    localparam int RndW     = $clog2(NumRnds);

    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

    localparam logic [WordW-1:0] Iv0 = 32'h67452301;
    localparam logic [WordW-1:0] Iv1 = 32'hEFCDAB89;
    localparam logic [WordW-1:0] Iv2 = 32'h98BADCFE;
    localparam logic [WordW-1:0] Iv3 = 32'h10325476;
    localparam logic [WordW-1:0] Iv4 = 32'hC3D2E1F0;

    localparam logic [7:0] PadMark = 8'h80;

    // five working / chaining words
    typedef struct packed {
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [WordW-1:0] c;
        logic [WordW-1:0] d;
        logic [WordW-1:0] e;
    } sha1s_vars_t;

    localparam sha1s_vars_t IvVars = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};

endpackage

>>> sv/sha1s_round.sv
module sha1s_round (
    input  logic [sha1s_pkg::RndW-1:0]  rnd,
    input  logic [sha1s_pkg::WordW-1:0] w,
    input  sha1s_pkg::sha1s_vars_t      vars_in,
    output sha1s_pkg::sha1s_vars_t      vars_out
);
    import sha1s_pkg::*;

    logic [WordW-1:0] f;
    logic [WordW-1:0] k;
    logic [WordW-1:0] sum;

    always_comb begin
        priority if (rnd < RndW'(20)) begin
            f = (vars_in.b & vars_in.c) | (~vars_in.b & vars_in.d);
            k = K0;
        end else if (rnd < RndW'(40)) begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = K1;
        end else if (rnd < RndW'(60)) begin
            f = (vars_in.b & vars_in.c) | (vars_in.b & vars_in.d) | (vars_in.c & vars_in.d);
            k = K2;
        end else begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = K3;
        end
    end

    assign sum = {vars_in.a[26:0], vars_in.a[31:27]} + f + vars_in.e + k + w;

    assign vars_out = '{a: sum,
                        b: vars_in.a,
                        c: {vars_in.b[1:0], vars_in.b[31:2]},
                        d: vars_in.c,
                        e: vars_in.d};

endmodule

>>> sv/sha1_stream_hash.sv
// Channel   Dir  Width  Carries
// s_        in   8+1+1  tdata = data_byte, tuser = has_byte, tlast = end_of_message
// m_        out  40+1   tdata = digest_word, word_index; tlast = last_word
//
// A word without a byte, or a byte that does not fill a block, leaves s_tready
// high unless it ends the message. A byte that fills a 64-byte block starts
// compression: one shared round unit runs 80 rounds, one per cycle, then ST_ADD
// folds the result into the chain. End of message pushes 9 to 72 pad bytes and
// compresses each padded block, then loads the digest; s_tready stays low.
// Reset (aresetn low, synchronous) restores the initial chain and empty block.
// The digest sits in its own five-word buffer, so the next message streams in
// while m_tready stalls; only the next digest load waits for the buffer.
module sha1_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast
);
    import sha1s_pkg::*;

    localparam logic [2:0] ST_IN   = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DIG  = 3'd4;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam logic [5:0] LenOff  = 6'd56;
    localparam logic [5:0] LastOff = 6'd63;
    localparam logic [2:0] LastIdx = 3'(NumWords - 1);

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       pad_act_reg, pad_act_next;
    logic       fin_reg, fin_next;
    logic [5:0] off_reg, off_next;
    logic [60:0] total_reg, total_next;
    logic [RndW-1:0] rnd_reg, rnd_next;

    // window: index 15 holds the oldest schedule word
    logic [WinDepth-1:0][WordW-1:0] win_reg, win_next;
    sha1s_vars_t chain_reg, chain_next;
    sha1s_vars_t vars_reg, vars_next;
    sha1s_vars_t vars_rnd;

    logic [NumWords-1:0][WordW-1:0] obuf_reg, obuf_next;
    logic [2:0] oidx_reg, oidx_next;
    logic       ovld_reg, ovld_next;

    logic       in_acc;
    logic       push_en;
    logic [7:0] push_byte;
    logic       push_len;
    logic       full;
    logic [63:0] len_bits;
    logic [WordW-1:0] w_new;

    sha1s_round u_round (
        .rnd      (rnd_reg),
        .w        (win_reg[WinDepth-1]),
        .vars_in  (vars_reg),
        .vars_out (vars_rnd)
    );

    assign s_tready = (state_reg == ST_IN);
    assign in_acc   = s_tvalid && s_tready;

    assign len_bits = {total_reg, 3'b000};
    assign push_len = (phase_reg == PH_LEN) || (phase_reg == PH_ZERO && off_reg == LenOff);

    always_comb begin
        if (state_reg == ST_PAD) begin
            push_en = 1'b1;
            if (phase_reg == PH_MARK) begin
                push_byte = PadMark;
            end else if (push_len) begin
                push_byte = len_bits[{~off_reg[2:0], 3'b000} +: 8];
            end else begin
                push_byte = 8'h00;
            end
        end else begin
            push_en   = in_acc && s_tuser;
            push_byte = s_tdata;
        end
    end

    assign full = push_en && (off_reg == LastOff);

    // W[t+16] from taps W[t+13], W[t+8], W[t+2], W[t]
    always_comb begin
        w_new = win_reg[2] ^ win_reg[7] ^ win_reg[13] ^ win_reg[15];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        pad_act_next = pad_act_reg;
        fin_next     = fin_reg;
        off_next     = off_reg;
        total_next   = total_reg;
        rnd_next     = rnd_reg;
        win_next     = win_reg;
        chain_next   = chain_reg;
        vars_next    = vars_reg;
        obuf_next    = obuf_reg;
        oidx_next    = oidx_reg;
        ovld_next    = ovld_reg;

        if (push_en) begin
            win_next = {win_reg[WinDepth-1][23:0], win_reg[WinDepth-2:0], push_byte};
            off_next = off_reg + 6'd1;
        end
        if (full) begin
            vars_next = chain_reg;
            rnd_next  = '0;
        end

        unique case (state_reg)
            ST_IN: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        total_next = total_reg + 61'd1;
                    end
                    if (s_tlast) begin
                        pad_act_next = 1'b1;
                        phase_next   = PH_MARK;
                    end
                    if (full) begin
                        state_next = ST_COMP;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (phase_reg == PH_MARK) begin
                    phase_next = PH_ZERO;
                end else if (push_len) begin
                    phase_next = PH_LEN;
                    if (off_reg == LastOff) begin
                        fin_next = 1'b1;
                    end
                end
                if (full) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                vars_next = vars_rnd;
                win_next  = {win_reg[WinDepth-2:0], w_new};
                rnd_next  = rnd_reg + RndW'(1);
                if (rnd_reg == RndW'(NumRnds - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next.a = chain_reg.a + vars_reg.a;
                chain_next.b = chain_reg.b + vars_reg.b;
                chain_next.c = chain_reg.c + vars_reg.c;
                chain_next.d = chain_reg.d + vars_reg.d;
                chain_next.e = chain_reg.e + vars_reg.e;
                if (fin_reg) begin
                    state_next = ST_DIG;
                end else if (pad_act_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IN;
                end
            end
            ST_DIG: begin
                if (!ovld_reg) begin
                    obuf_next    = {chain_reg.e, chain_reg.d, chain_reg.c,
                                    chain_reg.b, chain_reg.a};
                    oidx_next    = '0;
                    ovld_next    = 1'b1;
                    chain_next   = IvVars;
                    off_next     = '0;
                    total_next   = '0;
                    pad_act_next = 1'b0;
                    fin_next     = 1'b0;
                    state_next   = ST_IN;
                end
            end
            default: begin
                state_next = ST_IN;
            end
        endcase

        // drain the digest buffer, word 0 first
        if (ovld_reg && m_tready) begin
            obuf_next = {{WordW{1'b0}}, obuf_reg[NumWords-1:1]};
            oidx_next = oidx_reg + 3'd1;
            if (oidx_reg == LastIdx) begin
                ovld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IN;
            phase_reg   <= PH_MARK;
            pad_act_reg <= 1'b0;
            fin_reg     <= 1'b0;
            off_reg     <= '0;
            total_reg   <= '0;
            rnd_reg     <= '0;
            chain_reg   <= IvVars;
            oidx_reg    <= '0;
            ovld_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pad_act_reg <= pad_act_next;
            fin_reg     <= fin_next;
            off_reg     <= off_next;
            total_reg   <= total_next;
            rnd_reg     <= rnd_next;
            chain_reg   <= chain_next;
            oidx_reg    <= oidx_next;
            ovld_reg    <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
        obuf_reg <= obuf_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {5'b00000, oidx_reg, obuf_reg[0]};
    assign m_tlast  = (oidx_reg == LastIdx);

    // the chain fold always happens on a block boundary
    a_add_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD |-> off_reg == '0)
        else $error("chain fold with partial block");

    // digest stream ends only after its fifth word
    a_out_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tlast) && $past(m_tready))
        else $error("digest stream cut short");

    // a digest load starts at word 0
    a_dig_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIG && !ovld_reg |=> m_tvalid && m_tdata[34:32] == 3'd0)
        else $error("digest load misaligned");

endmodule
